// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that cons holds in the same cycle as ante
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// check that cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/kmh_pkg.sv -----
// Types, constants and key compare for the k-way merge heap
package kmh_pkg;

	localparam int LANES_DEF = 16;
	localparam int VALUE_W = 32;
	localparam int LANE_W = 4;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_REFILL = 1'b1;

	typedef struct packed {
		logic mode;
		logic [LANE_W-1:0] lane;
		logic signed [VALUE_W-1:0] value_in;
		logic present;
		logic last_head;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_out;
		logic [LANE_W-1:0] source_lane;
		logic done_res;
	} out_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [LANE_W-1:0] lane;
	} entry_t;

	function automatic logic key_less(entry_t a, entry_t b);
		logic res;
		if (a.value != b.value) begin
			res = ($signed(a.value) < $signed(b.value));
		end else begin
			res = (a.lane < b.lane);
		end
		return res;
	endfunction

endpackage

// ----- sv/kway_merge_min_heap.sv -----
// K-way merge of sorted signed lanes through a min-heap of lane heads held in one RAM.
// Load phase: each item with mode 0 pushes one lane head (or none when present is low);
// the item marked last_head starts the merge and yields the smallest head with its lane.
// Merge phase: each item with mode 1 refills the lane just named (or marks it exhausted)
// and yields the next minimum; once the heap is empty a done result is given and the block
// returns to the load phase. Ties leave lower lane first. Items are handled one at a time.
// All heap traffic goes through the RAM, one access per cycle at most. A push reads the
// parent at each level it climbs and moves a larger parent down, then writes the new entry
// at the root or below the first parent that is not larger. Taking the minimum reads the
// root and the last entry; unless the heap is then empty the last entry sinks down,
// reading the left and right child at each level and writing the smallest of the three,
// until it has no child or no child is smaller, where it is written. An empty heap gives a
// done result instead. The result waits in state OUT while a held result is stalled, then
// goes to the output register. No clearing pass is needed after reset.
module kway_merge_min_heap
	#(parameter int LANES = kmh_pkg::LANES_DEF)
	(
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input kmh_pkg::in_item_t item,
	output logic res_valid,
	input logic res_stall,
	output kmh_pkg::out_item_t res
	);

	import kmh_pkg::*;

	localparam int IDX_W = $clog2(LANES);
	localparam int CNT_W = $clog2(LANES + 1);
	localparam int CW = IDX_W + 2;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_PUSH_RD = 4'd1;
	localparam logic [3:0] ST_PUSH_CMP = 4'd2;
	localparam logic [3:0] ST_EMIT_RD = 4'd3;
	localparam logic [3:0] ST_EMIT_LAST = 4'd4;
	localparam logic [3:0] ST_POP_X = 4'd5;
	localparam logic [3:0] ST_DN_RDL = 4'd6;
	localparam logic [3:0] ST_DN_RDR = 4'd7;
	localparam logic [3:0] ST_DN_CMP = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic merging_q;
	logic emit_q;
	logic [LANE_W-1:0] pending_q;
	logic res_valid_q;
	out_item_t res_q;
	out_item_t res_buf_q;
	logic [IDX_W-1:0] pos_q;
	entry_t x_q;
	entry_t c_q;
	logic rvalid_q;

	logic accept;
	logic take;
	logic push_en;
	logic emit_en;
	logic out_free;
	logic [IDX_W-1:0] pos_m1;
	logic [IDX_W-1:0] parent;
	logic [CNT_W-1:0] cnt_m1;
	logic [CW-1:0] l_w;
	logic [CW-1:0] r_w;
	logic l_ok;
	logic r_ok;
	logic up_less;
	logic sel_l;
	logic sel_r;
	entry_t best;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t ram_wdata;
	logic ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic [$bits(entry_t)-1:0] ram_rdata;
	entry_t rdata;

	kmh_ram #(.WIDTH($bits(entry_t)), .DEPTH(LANES)) u_heap_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign rdata = entry_t'(ram_rdata);

	assign accept = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign take = merging_q ? (item.mode == MODE_REFILL) : (item.mode == MODE_LOAD);
	assign push_en = take && item.present && (count_q < CNT_W'(LANES));
	assign emit_en = take && (merging_q || item.last_head);
	assign out_free = !res_valid_q || !res_stall;

	assign pos_m1 = pos_q - IDX_W'(1);
	assign parent = pos_m1 >> 1;
	assign cnt_m1 = count_q - CNT_W'(1);
	assign l_w = CW'({pos_q, 1'b1});
	assign r_w = l_w + CW'(1);
	assign l_ok = (l_w < CW'(count_q));
	assign r_ok = (r_w < CW'(count_q));

	assign up_less = key_less(x_q, rdata);
	assign sel_l = key_less(c_q, x_q);
	assign best = sel_l ? c_q : x_q;
	assign sel_r = rvalid_q && key_less(rdata, best);

	always_comb begin
		ram_we = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_q;
		ram_re = 1'b0;
		ram_raddr = '0;
		case (state_q)
			ST_PUSH_RD: begin
				if (pos_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_re = 1'b1;
					ram_raddr = parent;
				end
			end
			ST_PUSH_CMP: begin
				ram_we = 1'b1;
				ram_wdata = up_less ? rdata : x_q;
			end
			ST_EMIT_RD: begin
				ram_re = (count_q != '0);
			end
			ST_EMIT_LAST: begin
				ram_re = 1'b1;
				ram_raddr = cnt_m1[IDX_W-1:0];
			end
			ST_DN_RDL: begin
				if (l_ok) begin
					ram_re = 1'b1;
					ram_raddr = l_w[IDX_W-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			ST_DN_RDR: begin
				ram_re = r_ok;
				ram_raddr = r_w[IDX_W-1:0];
			end
			ST_DN_CMP: begin
				ram_we = 1'b1;
				ram_wdata = sel_r ? rdata : best;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			merging_q <= 1'b0;
			emit_q <= 1'b0;
			pending_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						emit_q <= emit_en;
						if (take && !merging_q && item.last_head) begin
							merging_q <= 1'b1;
						end
						if (push_en) begin
							count_q <= count_q + CNT_W'(1);
							state_q <= ST_PUSH_RD;
						end else if (emit_en) begin
							state_q <= ST_EMIT_RD;
						end
					end
				end
				ST_PUSH_RD: begin
					if (pos_q == '0) begin
						state_q <= emit_q ? ST_EMIT_RD : ST_IDLE;
					end else begin
						state_q <= ST_PUSH_CMP;
					end
				end
				ST_PUSH_CMP: begin
					if (up_less) begin
						state_q <= ST_PUSH_RD;
					end else begin
						state_q <= emit_q ? ST_EMIT_RD : ST_IDLE;
					end
				end
				ST_EMIT_RD: begin
					state_q <= (count_q == '0) ? ST_OUT : ST_EMIT_LAST;
				end
				ST_EMIT_LAST: begin
					count_q <= cnt_m1;
					pending_q <= rdata.lane;
					state_q <= ST_POP_X;
				end
				ST_POP_X: begin
					state_q <= (count_q == '0) ? ST_OUT : ST_DN_RDL;
				end
				ST_DN_RDL: begin
					state_q <= l_ok ? ST_DN_RDR : ST_OUT;
				end
				ST_DN_RDR: begin
					state_q <= ST_DN_CMP;
				end
				ST_DN_CMP: begin
					state_q <= (sel_r || sel_l) ? ST_DN_RDL : ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						if (res_buf_q.done_res) begin
							merging_q <= 1'b0;
							pending_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q <= '{value: item.value_in,
						lane: merging_q ? pending_q : item.lane};
					pos_q <= count_q[IDX_W-1:0];
				end
			end
			ST_PUSH_CMP: begin
				if (up_less) begin
					pos_q <= parent;
				end
			end
			ST_EMIT_RD: begin
				if (count_q == '0) begin
					res_buf_q <= '{value_out: '0, source_lane: '0, done_res: 1'b1};
				end
			end
			ST_EMIT_LAST: begin
				res_buf_q <= '{value_out: rdata.value, source_lane: rdata.lane,
					done_res: 1'b0};
			end
			ST_POP_X: begin
				x_q <= rdata;
				pos_q <= '0;
			end
			ST_DN_RDR: begin
				c_q <= rdata;
				rvalid_q <= r_ok;
			end
			ST_DN_CMP: begin
				if (sel_r) begin
					pos_q <= r_w[IDX_W-1:0];
				end else if (sel_l) begin
					pos_q <= l_w[IDX_W-1:0];
				end
			end
			ST_OUT: begin
				if (out_free) begin
					res_q <= res_buf_q;
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

`include "assert_macros.svh"

	`ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(LANES))
	`ASSERT_SAME(a_ram_no_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr)
	`ASSERT_SAME(a_done_zero, clk, arst_n, res_valid_q && res_q.done_res,
		res_q.value_out == '0 && res_q.source_lane == '0)
	`ASSERT_SAME(a_done_leaves, clk, arst_n, $fell(merging_q),
		res_valid_q && res_q.done_res && count_q == '0)

endmodule

// ----- sv/kmh_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module kmh_ram
	#(parameter int WIDTH = 8,
	  parameter int DEPTH = 16)
	(
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
	);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the k-way merge min-heap: directed table, then random merges
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kmh_pkg::*;

	localparam int HEAP_SLOTS = LANES_DEF;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		in_item_t it;
		logic fixed;
		out_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	in_item_t item = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	out_item_t res;

	kway_merge_min_heap i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// merge predictor state
	entry_t pool[HEAP_SLOTS];
	int pool_n = 0;
	logic [LANE_W-1:0] refill_lane = '0;
	bit in_merge = 1'b0;

	out_item_t heads_due[$];
	dir_row_t dir_rows[$];
	longint lane_top[16];

	int send_gap_pct = 7;
	int recv_gap_pct = 82;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int faults = 0;
	int checked = 0;
	int dones = 0;
	int n_items = 0;
	int merges = 0;
	out_item_t head_want;

	function automatic in_item_t mk(logic mode, logic [3:0] lane, logic [31:0] v,
			logic present, logic last_head);
		in_item_t it;
		it.mode = mode;
		it.lane = lane;
		it.value_in = v;
		it.present = present;
		it.last_head = last_head;
		return it;
	endfunction

	function automatic out_item_t res_of(logic [31:0] v, logic [3:0] lane, logic done);
		out_item_t r;
		r.value_out = v;
		r.source_lane = lane;
		r.done_res = done;
		return r;
	endfunction

	function automatic bit lighter(entry_t a, entry_t b);
		if (a.value == b.value) begin
			return a.lane < b.lane;
		end
		return $signed(a.value) < $signed(b.value);
	endfunction

	function automatic void pool_add(logic [31:0] v, logic [3:0] lane);
		if (pool_n < HEAP_SLOTS) begin
			pool[pool_n].value = v;
			pool[pool_n].lane = lane;
			pool_n++;
		end
	endfunction

	function automatic bit merge_step(input in_item_t it, output out_item_t r);
		int best;
		r = '0;
		if (!in_merge) begin
			if (it.mode != MODE_LOAD) return 1'b0;
			if (it.present) pool_add(it.value_in, it.lane);
			if (!it.last_head) return 1'b0;
			in_merge = 1'b1;
		end else begin
			if (it.mode == MODE_LOAD) return 1'b0;
			if (it.present) pool_add(it.value_in, refill_lane);
		end
		if (pool_n == 0) begin
			r.done_res = 1'b1;
			refill_lane = '0;
			in_merge = 1'b0;
			return 1'b1;
		end
		best = 0;
		for (int i = 1; i < pool_n; i++) begin
			if (lighter(pool[i], pool[best])) best = i;
		end
		r.value_out = pool[best].value;
		r.source_lane = pool[best].lane;
		r.done_res = 1'b0;
		refill_lane = pool[best].lane;
		pool_n--;
		pool[best] = pool[pool_n];
		return 1'b1;
	endfunction

	task automatic offer(input in_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_and_predict(input in_item_t it, input bit counts);
		out_item_t r;
		offer(it);
		if (merge_step(it, r)) heads_due.push_back(r);
		if (counts) n_items++;
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (heads_due.size() != 0) @(posedge clk);
	endtask

	task automatic run_merge();
		int heads;
		int ln;
		longint nv;
		logic signed [31:0] v;
		in_item_t it;
		heads = ($urandom_range(9) == 0) ? $urandom_range(19, 15) : $urandom_range(6, 1);
		merges++;
		for (int h = 0; h < heads; h++) begin
			if ($urandom_range(99) < 3) begin
				it = mk(MODE_REFILL, 4'($urandom), $urandom, 1'($urandom), 1'($urandom));
				send_and_predict(it, 1'b0);
			end
			ln = $urandom_range(15);
			case ($urandom_range(3))
				0: v = $urandom;
				1: v = $urandom_range(40) - 20;
				2: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
				default: v = $signed($urandom) >>> $urandom_range(31);
			endcase
			it = mk(MODE_LOAD, 4'(ln), v, $urandom_range(9) != 0, h == heads - 1);
			if (it.present) lane_top[ln] = longint'(v);
			send_and_predict(it, 1'b1);
		end
		while (in_merge) begin
			if ($urandom_range(99) < 3) begin
				it = mk(MODE_LOAD, 4'($urandom), $urandom, 1'($urandom), 1'($urandom));
				send_and_predict(it, 1'b0);
			end else begin
				ln = int'(refill_lane);
				if ($urandom_range(19) == 0) begin
					v = $urandom;
				end else begin
					nv = lane_top[ln] + longint'($urandom_range(50));
					if (nv > 64'sd2147483647) nv = 64'sd2147483647;
					v = nv[31:0];
				end
				it = mk(MODE_REFILL, 4'($urandom), v, $urandom_range(4) != 0,
					1'($urandom));
				if (it.present) lane_top[ln] = longint'(v);
				send_and_predict(it, 1'b1);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			checked++;
			if (res.done_res) dones++;
			if (heads_due.size() == 0) begin
				$error("result with no transaction pending: value_out %0d source_lane %0d done_res %0b",
					res.value_out, res.source_lane, res.done_res);
				faults++;
			end else begin
				head_want = heads_due.pop_front();
				if (res.value_out !== head_want.value_out) begin
					$error("value_out: expected %0d, got %0d", head_want.value_out, res.value_out);
					faults++;
				end
				if (res.source_lane !== head_want.source_lane) begin
					$error("source_lane: expected %0d, got %0d", head_want.source_lane,
						res.source_lane);
					faults++;
				end
				if (res.done_res !== head_want.done_res) begin
					$error("done_res: expected %0b, got %0b", head_want.done_res, res.done_res);
					faults++;
				end
			end
		end
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_gap_pct);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		out_item_t r;
		int target;
		foreach (lane_top[i]) lane_top[i] = 0;

		dir_rows.push_back('{mk(MODE_REFILL, 4'd9, 32'h7fffffff, 1'b1, 1'b1), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd0, 32'd0, 1'b0, 1'b1), 1'b1,
			res_of(32'd0, 4'd0, 1'b1)});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd3, 32'd5, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd1, 32'd5, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd15, 32'h7fffffff, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd2, 32'h80000000, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd2, -32'sd7, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd4, 32'd123, 1'b0, 1'b1), 1'b1,
			res_of(32'h80000000, 4'd2, 1'b0)});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd6, -32'sd1, 1'b1, 1'b1), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, -32'sd100, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd15, 32'd0, 1'b0, 1'b1), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'hffffffff, 1'b0, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd7, 32'd0, 1'b0, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'd5, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'd0, 1'b0, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'h7fffffff, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'd0, 1'b0, 1'b0), 1'b1,
			res_of(32'd0, 4'd0, 1'b1)});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd5, 32'd42, 1'b1, 1'b0), 1'b0, '0});
		dir_rows.push_back('{mk(MODE_LOAD, 4'd15, 32'hffffffff, 1'b1, 1'b1), 1'b1,
			res_of(32'hffffffff, 4'd15, 1'b0)});
		dir_rows.push_back('{mk(MODE_REFILL, 4'd0, 32'd0, 1'b0, 1'b0), 1'b1,
			res_of(32'd0, 4'd0, 1'b1)});

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer(dir_rows[i].it);
			if (merge_step(dir_rows[i].it, r)) begin
				heads_due.push_back(dir_rows[i].fixed ? dir_rows[i].want : r);
			end
			n_items++;
		end
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 7;
					recv_gap_pct = 82;
				end
				1: begin
					send_gap_pct = 82;
					recv_gap_pct = 7;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
					hold_asks <= hold_asks + 1;
				end
			endcase
			target = n_items + 460;
			while (n_items < target) run_merge();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d item transactions over %0d random merges and a directed table;",
			n_items, merges);
		$display("checked %0d results, %0d of them done results, %0d mismatches",
			checked, dones, faults);
		if (faults == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
